@@ rtl/frs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the fraction sum reducer.
package frs_pkg;

  // Default widths of an input fraction field and of the accumulators
  localparam int INPUT_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF   = 64;

  // Widest accumulator slice fed to one multiplier in a cycle
  localparam int CHUNK_MAX = 32;

endpackage

@@ rtl/frs_front.sv @@
`timescale 1ns / 1ps
// Front end: takes input items, cleans them up and holds them in a two-entry queue.
module frs_front #(
  parameter int INPUT_WIDTH = frs_pkg::INPUT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // upstream queue side
  input  logic                   push,
  output logic                   full,
  input  logic [INPUT_WIDTH-1:0] numerator,
  input  logic [INPUT_WIDTH-1:0] denominator,
  input  logic                   last_item,
  // towards the back end
  output logic                   item_valid,
  input  logic                   item_ready,
  output logic [INPUT_WIDTH-1:0] item_n,
  output logic [INPUT_WIDTH-1:0] item_d,
  output logic                   item_last
);

  logic [INPUT_WIDTH-1:0] q_n    [2];
  logic [INPUT_WIDTH-1:0] q_d    [2];
  logic                   q_last [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   do_push;
  logic                   do_pop;
  logic [INPUT_WIDTH-1:0] d_clean;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign do_push    = push && !full;
  assign do_pop     = item_valid && item_ready;

  // a zero denominator counts as one
  assign d_clean = (denominator == '0) ? INPUT_WIDTH'(1) : denominator;

  // head of queue
  assign item_n    = q_n[rd_ptr];
  assign item_d    = q_d[rd_ptr];
  assign item_last = q_last[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_n[wr_ptr]    <= numerator;
      q_d[wr_ptr]    <= d_clean;
      q_last[wr_ptr] <= last_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/frs_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, gives quotient and remainder.
module frs_div #(
  parameter int WIDTH = frs_pkg::ACC_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNTW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CNTW-1:0]  cnt;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {remainder, quotient[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        remainder <= '0;
        quotient  <= dividend;
        dvs       <= divisor;
      end else if (busy) begin
        if (!diff[WIDTH]) begin
          remainder <= diff[WIDTH-1:0];
          quotient  <= {quotient[WIDTH-2:0], 1'b1};
        end else begin
          remainder <= trial[WIDTH-1:0];
          quotient  <= {quotient[WIDTH-2:0], 1'b0};
        end
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/frs_back.sv @@
`timescale 1ns / 1ps
// Back end: accumulates the running sum, runs Euclid's gcd and reduces the result.
module frs_back #(
  parameter int INPUT_WIDTH = frs_pkg::INPUT_WIDTH_DEF,
  parameter int ACC_WIDTH   = frs_pkg::ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // from the front end
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [INPUT_WIDTH-1:0] item_n,
  input  logic [INPUT_WIDTH-1:0] item_d,
  input  logic                   item_last,
  // result register, queue style
  output logic                   empty,
  input  logic                   pop,
  output logic [ACC_WIDTH-1:0]   reduced_numerator,
  output logic [ACC_WIDTH-1:0]   reduced_denominator,
  output logic                   whole_number,
  output logic                   overflow
);

  localparam int CW     = (ACC_WIDTH < frs_pkg::CHUNK_MAX) ? ACC_WIDTH : frs_pkg::CHUNK_MAX;
  localparam int CHUNKS = (ACC_WIDTH + CW - 1) / CW;
  localparam int KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PADW   = CHUNKS * CW;
  localparam int PW     = ACC_WIDTH + INPUT_WIDTH;
  localparam int MW     = CW + INPUT_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_GCD, S_GWAIT, S_QN, S_QNW, S_QD, S_QDW, S_OUT
  } state_t;

  state_t                 state;
  logic [ACC_WIDTH-1:0]   sum_n;
  logic [ACC_WIDTH-1:0]   sum_d;
  logic                   ovf_seen;
  logic [INPUT_WIDTH-1:0] cur_n;
  logic [INPUT_WIDTH-1:0] cur_d;
  logic                   cur_last;
  logic [KW-1:0]          k;
  logic [PW-1:0]          pr1;
  logic [PW-1:0]          pr2;
  logic [PW-1:0]          pr3;
  logic [ACC_WIDTH-1:0]   ga;
  logic [ACC_WIDTH-1:0]   gb;
  logic [ACC_WIDTH-1:0]   gcd;
  logic [ACC_WIDTH-1:0]   rn;
  logic [ACC_WIDTH-1:0]   rd;
  logic                   rd_whole;
  logic                   res_valid;

  logic [PADW-1:0]        sn_pad;
  logic [PADW-1:0]        sd_pad;
  logic [CW-1:0]          sn_chunk;
  logic [CW-1:0]          sd_chunk;
  logic [MW-1:0]          m1;
  logic [MW-1:0]          m2;
  logic [MW-1:0]          m3;
  logic [ACC_WIDTH:0]     add_sum;
  logic                   ovf_item;

  logic                   div_start;
  logic [ACC_WIDTH-1:0]   div_dividend;
  logic [ACC_WIDTH-1:0]   div_divisor;
  logic                   div_done;
  logic [ACC_WIDTH-1:0]   div_quo;
  logic [ACC_WIDTH-1:0]   div_rem;

  assign item_ready = (state == S_IDLE);
  assign empty      = !res_valid;

  // one slice of each accumulator per cycle through three multipliers
  assign sn_pad   = PADW'(sum_n);
  assign sd_pad   = PADW'(sum_d);
  assign sn_chunk = sn_pad[k*CW +: CW];
  assign sd_chunk = sd_pad[k*CW +: CW];
  assign m1 = MW'(sn_chunk) * MW'(cur_d);
  assign m2 = MW'(sd_chunk) * MW'(cur_n);
  assign m3 = MW'(sd_chunk) * MW'(cur_d);

  // final add and overflow of this item: any product bit above the width, or a carry
  assign add_sum  = {1'b0, pr1[ACC_WIDTH-1:0]} + {1'b0, pr2[ACC_WIDTH-1:0]};
  assign ovf_item = (pr1[PW-1:ACC_WIDTH] != '0) || (pr2[PW-1:ACC_WIDTH] != '0) ||
                    (pr3[PW-1:ACC_WIDTH] != '0) || add_sum[ACC_WIDTH];

  // divider requests: Euclid remainder, then the two reductions
  always_comb begin
    div_start    = 1'b0;
    div_dividend = gb;
    div_divisor  = ga;
    unique case (state)
      S_GCD: begin
        div_start = (ga != '0);
      end
      S_QN: begin
        div_start    = 1'b1;
        div_dividend = sum_n;
        div_divisor  = gcd;
      end
      S_QD: begin
        div_start    = 1'b1;
        div_dividend = sum_d;
        div_divisor  = gcd;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  frs_div #(
    .WIDTH(ACC_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // sequencer, accumulators and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum_n     <= '0;
      sum_d     <= ACC_WIDTH'(1);
      ovf_seen  <= 1'b0;
      res_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (res_valid && pop) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_n    <= item_n;
            cur_d    <= item_d;
            cur_last <= item_last;
            pr1      <= '0;
            pr2      <= '0;
            pr3      <= '0;
            k        <= '0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          pr1 <= pr1 + (PW'(m1) << (k * CW));
          pr2 <= pr2 + (PW'(m2) << (k * CW));
          pr3 <= pr3 + (PW'(m3) << (k * CW));
          k   <= k + KW'(1);
          if (k == KW'(CHUNKS - 1)) state <= S_ADD;
        end
        S_ADD: begin
          sum_n    <= add_sum[ACC_WIDTH-1:0];
          sum_d    <= pr3[ACC_WIDTH-1:0];
          ovf_seen <= ovf_seen || ovf_item;
          ga       <= pr3[ACC_WIDTH-1:0];
          gb       <= add_sum[ACC_WIDTH-1:0];
          state    <= cur_last ? S_GCD : S_IDLE;
        end
        S_GCD: begin
          // loop ends when the divisor side reaches zero; a zero gcd counts as one
          if (ga == '0) begin
            gcd   <= (gb == '0) ? ACC_WIDTH'(1) : gb;
            state <= S_QN;
          end else begin
            state <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (div_done) begin
            gb    <= ga;
            ga    <= div_rem;
            state <= S_GCD;
          end
        end
        S_QN: begin
          state <= S_QNW;
        end
        S_QNW: begin
          if (div_done) begin
            rn    <= div_quo;
            state <= S_QD;
          end
        end
        S_QD: begin
          state <= S_QDW;
        end
        S_QDW: begin
          // wait for the denominator divide to finish
          if (div_done) begin
            rd       <= div_quo;
            rd_whole <= (div_quo == ACC_WIDTH'(1));
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for the result slot, then start a fresh sum
          if (!res_valid) begin
            reduced_numerator   <= rn;
            reduced_denominator <= rd;
            whole_number        <= rd_whole;
            overflow            <= ovf_seen;
            res_valid           <= 1'b1;
            sum_n               <= '0;
            sum_d               <= ACC_WIDTH'(1);
            ovf_seen            <= 1'b0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/fraction_sum_reducer.sv @@
`timescale 1ns / 1ps
// Top level of the fraction sum reducer: front queue, accumulator back end.
//
// Usage: fractions enter on the input queue (push/full) as numerator,
// denominator and last_item; a zero denominator counts as one. Every item is
// added to an unreduced running sum. The item marked last_item closes the sum:
// the gcd of both sums is found by Euclid's remainder loop and one reduced
// fraction is offered on the result queue (empty/pop) with whole_number and
// overflow flags. The sum then restarts at 0/1.
// An item that is not last occupies the back end while its ACC_WIDTH/32
// accumulator slices (rounded up, at least one) pass through the three
// 32-bit-slice multipliers and the final add. A last item adds the
// reduction: Euclid remainder steps, then two divides by the gcd, all on
// the one bit-serial divider, then closing the loop and loading the result.
// A two-item queue lets the front keep accepting while the back end works.
// Reset clears the queues and returns the sum to 0/1 with no overflow.
// A result waiting on a stalled receiver holds the back end at the end of
// the next reduction only; accumulation of following items carries on.
module fraction_sum_reducer #(
  parameter int INPUT_WIDTH = frs_pkg::INPUT_WIDTH_DEF,
  parameter int ACC_WIDTH   = frs_pkg::ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [INPUT_WIDTH-1:0] numerator,
  input  logic [INPUT_WIDTH-1:0] denominator,
  input  logic                   last_item,
  output logic                   empty,
  input  logic                   pop,
  output logic [ACC_WIDTH-1:0]   reduced_numerator,
  output logic [ACC_WIDTH-1:0]   reduced_denominator,
  output logic                   whole_number,
  output logic                   overflow
);

  logic                   item_valid;
  logic                   item_ready;
  logic [INPUT_WIDTH-1:0] item_n;
  logic [INPUT_WIDTH-1:0] item_d;
  logic                   item_last;

  // input queue
  frs_front #(
    .INPUT_WIDTH(INPUT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .numerator   (numerator),
    .denominator (denominator),
    .last_item   (last_item),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item_n      (item_n),
    .item_d      (item_d),
    .item_last   (item_last)
  );

  // accumulate and reduce
  frs_back #(
    .INPUT_WIDTH(INPUT_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .item_n              (item_n),
    .item_d              (item_d),
    .item_last           (item_last),
    .empty               (empty),
    .pop                 (pop),
    .reduced_numerator   (reduced_numerator),
    .reduced_denominator (reduced_denominator),
    .whole_number        (whole_number),
    .overflow            (overflow)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the fraction sum reducer: random fraction sums checked against a predictor.
module tb_top;

  localparam int INW            = frs_pkg::INPUT_WIDTH_DEF;
  localparam int ACCW           = frs_pkg::ACC_WIDTH_DEF;
  localparam int ITEM_TARGET    = 1250;
  localparam int CALM_ITEMS     = 150;
  localparam int HOLD_CYCLES    = 3000;
  localparam int HOLD_AFTER     = 12;
  // Longest reduction is about 93 Euclid steps plus two divides on the serial divider;
  // the long receiver hold-off adds HOLD_CYCLES.
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int REPORT_MAX     = 10;

  typedef logic [ACCW-1:0] acc_t;
  typedef logic [INW-1:0]  fld_t;

  typedef struct {
    acc_t num;
    acc_t den;
    logic whole;
    logic ovf;
  } reduced_frac_t;

  // Running fraction sum and the queue of reduced sums still owed by the block
  class sum_tracker;
    acc_t          acc_num;
    acc_t          acc_den;
    bit            acc_ovf;
    reduced_frac_t owed_sums[$];
    int            mismatches;
    int            results_seen;

    function new();
      clear_sum();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void clear_sum();
      acc_num = '0;
      acc_den = acc_t'(1);
      acc_ovf = 1'b0;
    endfunction

    // Product wraps to ACCW bits; any lost upper bit marks the sum overflowed
    function acc_t wrap_mul(acc_t a, acc_t b);
      logic [2*ACCW-1:0] p;
      p = {{ACCW{1'b0}}, a} * {{ACCW{1'b0}}, b};
      if (p[2*ACCW-1:ACCW] != '0) acc_ovf = 1'b1;
      return p[ACCW-1:0];
    endfunction

    function acc_t wrap_add(acc_t a, acc_t b);
      logic [ACCW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[ACCW]) acc_ovf = 1'b1;
      return s[ACCW-1:0];
    endfunction

    // Remainder loop starting from the denominator; a zero gcd counts as one
    function acc_t common_divisor(acc_t den, acc_t num);
      acc_t x;
      acc_t y;
      acc_t t;
      x = den;
      y = num;
      while (x != '0) begin
        t = x;
        x = y % x;
        y = t;
      end
      return (y == '0) ? acc_t'(1) : y;
    endfunction

    function void note_fraction(fld_t n, fld_t d, logic last);
      acc_t          nn;
      acc_t          dd;
      acc_t          p1;
      acc_t          p2;
      acc_t          g;
      reduced_frac_t r;
      nn = '0;
      dd = '0;
      nn[INW-1:0] = n;
      dd[INW-1:0] = d;
      if (dd == '0) dd = acc_t'(1);
      p1      = wrap_mul(acc_num, dd);
      p2      = wrap_mul(nn, acc_den);
      acc_num = wrap_add(p1, p2);
      acc_den = wrap_mul(acc_den, dd);
      if (!last) return;
      g       = common_divisor(acc_den, acc_num);
      r.num   = acc_num / g;
      r.den   = acc_den / g;
      r.whole = (r.den == acc_t'(1));
      r.ovf   = acc_ovf;
      owed_sums.push_back(r);
      clear_sum();
    endfunction

    function void check_reduced(acc_t num, acc_t den, logic whole, logic ovf);
      reduced_frac_t e;
      results_seen++;
      if (owed_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %0d/%0d whole=%0b ovf=%0b", num, den, whole, ovf);
        return;
      end
      e = owed_sums.pop_front();
      if (num !== e.num || den !== e.den || whole !== e.whole || ovf !== e.ovf) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d: expected %0d/%0d whole=%0b ovf=%0b, got %0d/%0d whole=%0b ovf=%0b",
                   results_seen, e.num, e.den, e.whole, e.ovf, num, den, whole, ovf);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  fld_t numerator;
  fld_t denominator;
  logic last_item;
  logic empty;
  logic pop;
  acc_t reduced_numerator;
  acc_t reduced_denominator;
  logic whole_number;
  logic overflow;

  sum_tracker tracker = new();
  int         items_sent = 0;
  bit         calm = 1'b0;
  int         stuck_cycles = 0;

  fraction_sum_reducer #(
    .INPUT_WIDTH(INW),
    .ACC_WIDTH  (ACCW)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .numerator          (numerator),
    .denominator        (denominator),
    .last_item          (last_item),
    .empty              (empty),
    .pop                (pop),
    .reduced_numerator  (reduced_numerator),
    .reduced_denominator(reduced_denominator),
    .whole_number       (whole_number),
    .overflow           (overflow)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one fraction, with an occasional idle burst first, and wait for it to be taken
  task automatic send_fraction(input fld_t n, input fld_t d, input logic last);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    push        <= 1'b1;
    numerator   <= n;
    denominator <= d;
    last_item   <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_fraction(n, d, last);
    items_sent++;
  endtask

  // The same fraction several times, closing the sum on the final copy
  task automatic send_run(input fld_t n, input fld_t d, input int count);
    for (int i = 0; i < count; i++) send_fraction(n, d, i == count - 1);
  endtask

  // One random sum; most use small denominators so the result stays exact
  task automatic send_random_sum();
    int   len;
    bit   big;
    fld_t n;
    fld_t d;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 5);
    big = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       n = '0;
        1:       n = fld_t'($urandom_range(0, 15));
        2:       n = '1;
        default: n = fld_t'($urandom);
      endcase
      case ($urandom_range(0, 15))
        0:       d = '0;
        1:       d = '1;
        2, 3:    d = fld_t'($urandom);
        default: d = big ? fld_t'($urandom) : fld_t'($urandom_range(1, 255));
      endcase
      if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      send_fraction(n, d, i == len - 1);
    end
  endtask

  // Sender
  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    numerator   = '0;
    denominator = fld_t'(1);
    last_item   = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero denominator, overflow and wrapped denominator
    send_run('0, fld_t'(1), 1);
    send_run('1, fld_t'(1), 1);
    send_run(fld_t'(1), '1, 1);
    send_run('1, '1, 1);
    send_run(fld_t'(3), '0, 1);
    send_fraction(fld_t'(1), fld_t'(2), 1'b0);
    send_fraction(fld_t'(1), fld_t'(3), 1'b0);
    send_fraction(fld_t'(1), fld_t'(6), 1'b1);
    send_run('1, '1, 5);
    send_run(fld_t'(1), fld_t'(16'h8000), 5);
    send_run('0, fld_t'(16'h8000), 5);

    while (items_sent < ITEM_TARGET) send_random_sum();

    @(negedge clk);
    push <= 1'b0;
    while (tracker.owed_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed_sums.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    bit held;
    held = 1'b0;
    pop  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && tracker.results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Result check
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      tracker.check_reduced(reduced_numerator, reduced_denominator, whole_number, overflow);
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
